// ===== rtl/crc_codeword_packer_assert.svh =====
// assertion macros used by the checker file
`ifndef CRC_CODEWORD_PACKER_ASSERT_SVH
`define CRC_CODEWORD_PACKER_ASSERT_SVH

// concurrent assertion on a given clock and active-low reset
`define CCP_ASSERT_CR(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) else $error(msg);

// concurrent assertion on the local clk and rst_n
`define CCP_ASSERT(label, prop, msg) \
    `CCP_ASSERT_CR(label, clk, rst_n, prop, msg)

`endif

// ===== rtl/ccp_pkg.sv =====
// shared types and constants of the crc codeword packer
`default_nettype none

package ccp_pkg;

    // field widths
    localparam int BYTE_W     = 8;
    localparam int POLY_W     = 16;
    localparam int CRC_WW     = 5;
    localparam int MSG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // header byte plus up to seven pad bits lead a message
    localparam int PAD_MAX    = 7;
    localparam int HDR_SPAN   = BYTE_W + PAD_MAX;

    // defaults
    localparam int DEFAULT_MAX_CRC_WIDTH = 16;
    localparam int QUEUE_DEPTH           = 4;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CRC_POLY      = 3'd0,
        CFG_CRC_WIDTH     = 3'd1,
        CFG_NIBBLE_MODE   = 3'd2,
        CFG_MESSAGE_BYTES = 3'd3
    } cfg_index_t;

    // configuration register set
    typedef struct packed {
        logic [POLY_W-1:0] crc_poly;
        logic [CRC_WW-1:0] crc_width;
        logic              nibble_mode;
        logic [MSG_W-1:0]  message_bytes;
    } ccp_cfg_t;

    // reset values
    localparam logic [POLY_W-1:0] RST_CRC_POLY      = 16'd3;
    localparam logic [CRC_WW-1:0] RST_CRC_WIDTH     = 5'd3;
    localparam logic              RST_NIBBLE_MODE   = 1'b0;
    localparam logic [MSG_W-1:0]  RST_MESSAGE_BYTES = 16'd1;

endpackage

`default_nettype wire

// ===== rtl/ccp_if.sv =====
// valid/ready channel interfaces for message bytes and packed bytes
`default_nettype none

interface ccp_in_if import ccp_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface ccp_out_if import ccp_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last_out;

    modport source (output valid, output out_byte, output last_out, input ready);
    modport sink   (input valid, input out_byte, input last_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/ccp_fifo.sv =====
// small register queue between the front and back parts
`default_nettype none

module ccp_fifo import ccp_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // status
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ccp_front.sv =====
// front part: takes message bytes, computes codewords and builds bit chunks
`default_nettype none

module ccp_front import ccp_pkg::*;
#(
    parameter int CRC_W   = DEFAULT_MAX_CRC_WIDTH,
    parameter int CHUNK_W = HDR_SPAN + BYTE_W + 2 * DEFAULT_MAX_CRC_WIDTH,
    parameter int LEN_W   = $clog2(CHUNK_W + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ccp_cfg_t           cfg,
    ccp_in_if.sink             msg_in,
    input  logic               full,
    output logic               push,
    output logic [CHUNK_W-1:0] chunk,
    output logic [LEN_W-1:0]   chunk_len,
    output logic               msg_end
);

    localparam int SEQ_W  = CHUNK_W - HDR_SPAN;
    localparam int NIB_W  = BYTE_W / 2;
    localparam int CODE_N = NIB_W + CRC_W;

    logic [MSG_W-1:0]  bytes_seen_reg;
    logic [MSG_W-1:0]  bytes_seen_next;
    logic [MSG_W-1:0]  seen_inc;
    logic [MSG_W-1:0]  msg_len;
    logic              hdr;

    logic [CRC_WW-1:0] w;
    logic [CRC_W-1:0]  poly_la;
    logic [CRC_W-1:0]  rem0;
    logic [CRC_W-1:0]  rem1;
    logic [5:0]        sh1;
    logic [SEQ_W-1:0]  seq_byte;
    logic [SEQ_W-1:0]  seq_nib;
    logic [SEQ_W-1:0]  seq;
    logic [SEQ_W+PAD_MAX-1:0] tail;

    logic [2:0]        low3;
    logic [2:0]        msg_lo;
    logic [5:0]        prod;
    logic [2:0]        pad;
    logic [LEN_W-1:0]  hdr_len;
    logic [LEN_W-1:0]  code_len;

    // msb-aligned bitwise crc over up to eight data bits
    function automatic logic [CRC_W-1:0] crc_la(input logic [BYTE_W-1:0] d,
                                               input logic four,
                                               input logic [CRC_W-1:0] p);
        logic [CRC_W-1:0] r;
        logic             fb;
        r  = '0;
        fb = 1'b0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (!four || i < NIB_W)
            begin
                fb = d[BYTE_W-1-i] ^ r[CRC_W-1];
                r  = r << 1;
                if (fb)
                begin
                    r = r ^ p;
                end
            end
        end
        return r;
    endfunction

    // effective width and generator aligned to the top of the crc register
    always_comb
    begin
        w = (cfg.crc_width > CRC_WW'(CRC_W)) ? CRC_WW'(CRC_W) : cfg.crc_width;
        poly_la = cfg.crc_poly[CRC_W-1:0] << (CRC_WW'(CRC_W) - w);
    end

    // remainders: high nibble or whole byte, and low nibble
    assign rem0 = crc_la(msg_in.data_byte, cfg.nibble_mode, poly_la);
    assign rem1 = crc_la({msg_in.data_byte[NIB_W-1:0], {NIB_W{1'b0}}}, 1'b1, poly_la);

    // codeword sequence, msb aligned, zeros below its length
    always_comb
    begin
        sh1      = 6'(NIB_W) + 6'(w);
        seq_byte = {msg_in.data_byte, rem0, {CRC_W{1'b0}}};
        seq_nib  = {msg_in.data_byte[BYTE_W-1:NIB_W], rem0, {CODE_N{1'b0}}}
                 | ({msg_in.data_byte[NIB_W-1:0], rem1, {CODE_N{1'b0}}} >> sh1);
        seq      = cfg.nibble_mode ? seq_nib : seq_byte;
    end

    // pad count from the low bits of the message length in bits
    always_comb
    begin
        low3    = cfg.nibble_mode ? {w[1:0], 1'b0} : w[2:0];
        msg_lo  = (cfg.message_bytes == '0) ? 3'd1 : cfg.message_bytes[2:0];
        prod    = 6'(msg_lo) * 6'(low3);
        pad     = 3'd0 - prod[2:0];
    end

    // message position
    always_comb
    begin
        hdr      = (bytes_seen_reg == '0);
        msg_len  = (cfg.message_bytes == '0) ? MSG_W'(1) : cfg.message_bytes;
        seen_inc = bytes_seen_reg + 1'b1;
        msg_end  = (seen_inc >= msg_len);
    end

    // chunk: optional header byte and pad bits, then the codewords
    always_comb
    begin
        tail      = {seq, {PAD_MAX{1'b0}}} >> pad;
        chunk     = hdr ? {5'b0, pad, tail} : {seq, {HDR_SPAN{1'b0}}};
        hdr_len   = hdr ? (LEN_W'(BYTE_W) + LEN_W'(pad)) : '0;
        code_len  = cfg.nibble_mode ? (LEN_W'(BYTE_W) + LEN_W'({w, 1'b0}))
                                    : (LEN_W'(BYTE_W) + LEN_W'(w));
        chunk_len = hdr_len + code_len;
    end

    // handshake
    assign msg_in.ready = !full;
    assign push         = msg_in.valid && !full;

    // byte count within the message
    always_comb
    begin
        bytes_seen_next = bytes_seen_reg;
        if (push)
        begin
            bytes_seen_next = msg_end ? '0 : seen_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_seen_reg <= '0;
        end
        else
        begin
            bytes_seen_reg <= bytes_seen_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ccp_back.sv =====
// back part: packs chunks into a bit buffer and sends one byte a cycle when the output is not stalled
`default_nettype none

module ccp_back import ccp_pkg::*;
#(
    parameter int CHUNK_W = HDR_SPAN + BYTE_W + 2 * DEFAULT_MAX_CRC_WIDTH,
    parameter int LEN_W   = $clog2(CHUNK_W + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  logic [CHUNK_W-1:0] q_chunk,
    input  logic [LEN_W-1:0]   q_len,
    input  logic               q_end,
    output logic               q_pop,
    ccp_out_if.source          code_out
);

    localparam int BUF_W  = CHUNK_W + PAD_MAX;
    localparam int FILL_W = $clog2(BUF_W + 1);

    logic [BUF_W-1:0]  bits_reg;
    logic [BUF_W-1:0]  bits_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              end_reg;
    logic              end_next;
    logic              valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;

    logic              out_free;
    logic              has8;
    logic              do_emit;
    logic              emit_last;
    logic [FILL_W-1:0] fill_after;
    logic [BUF_W-1:0]  bits_after;
    logic              end_after;
    logic [BUF_W-1:0]  loaded;

    // emit a byte when eight bits wait, or flush the tail of a message
    always_comb
    begin
        out_free   = !valid_reg || code_out.ready;
        has8       = (fill_reg >= FILL_W'(BYTE_W));
        do_emit    = (has8 || (end_reg && fill_reg != '0)) && out_free;
        emit_last  = end_reg && (fill_reg <= FILL_W'(BYTE_W));
        fill_after = fill_reg;
        bits_after = bits_reg;
        if (do_emit)
        begin
            fill_after = has8 ? (fill_reg - FILL_W'(BYTE_W)) : '0;
            bits_after = bits_reg << BYTE_W;
        end
        end_after  = end_reg && !(do_emit && emit_last);
    end

    // load the next chunk behind the remaining bits
    always_comb
    begin
        q_pop     = q_valid && (fill_after < FILL_W'(BYTE_W)) && !end_after;
        loaded    = {q_chunk, {PAD_MAX{1'b0}}} >> fill_after[2:0];
        bits_next = bits_after;
        fill_next = fill_after;
        end_next  = end_after;
        if (q_pop)
        begin
            bits_next = bits_after | loaded;
            fill_next = fill_after + FILL_W'(q_len);
            end_next  = q_end;
        end
    end

    // buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg  <= '0;
            fill_reg  <= '0;
            end_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            bits_reg <= bits_next;
            fill_reg <= fill_next;
            end_reg  <= end_next;
            if (do_emit)
            begin
                valid_reg <= 1'b1;
            end
            else if (code_out.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // output item register
    always_ff @(posedge clk)
    begin
        if (do_emit)
        begin
            byte_reg <= bits_reg[BUF_W-1 -: BYTE_W];
            last_reg <= emit_last;
        end
    end

    assign code_out.valid    = valid_reg;
    assign code_out.out_byte = byte_reg;
    assign code_out.last_out = last_reg;

endmodule

`default_nettype wire

// ===== rtl/crc_codeword_packer.sv =====
// top level of the crc codeword packer
//
// Takes one message byte per item and returns packed CRC codewords, one byte per
// output item. The first byte of a message produces a header byte with the pad
// count, followed by that many zero bits; the final byte of the message carries
// last_out. The front accepts one item per cycle while its four-entry queue has
// room. The back sends one output byte per cycle while code_out.ready does not
// stall it. An item packs into 8 + w bits per byte, or 2 * (4 + w) bits
// in nibble mode, plus 8 + pad bits on the first byte of a message. An accepted
// item is stored in the queue, loaded into the bit buffer and then registered in
// the output register before its first byte is valid. Configuration is written
// through cfg_we, cfg_index and cfg_data; the user must write it only while the
// block is idle, which the block itself does not enforce. Indexes beyond the
// register list are ignored.
`default_nettype none

module crc_codeword_packer import ccp_pkg::*;
#(
    parameter int MAX_CRC_WIDTH = DEFAULT_MAX_CRC_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    ccp_in_if.sink                msg_in,
    ccp_out_if.source             code_out,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CRC_W   = (MAX_CRC_WIDTH < POLY_W) ? MAX_CRC_WIDTH : POLY_W;
    localparam int CHUNK_W = HDR_SPAN + BYTE_W + 2 * CRC_W;
    localparam int LEN_W   = $clog2(CHUNK_W + 1);
    localparam int ENTRY_W = 1 + LEN_W + CHUNK_W;

    ccp_cfg_t           cfg_reg;
    logic               full;
    logic               push;
    logic [CHUNK_W-1:0] chunk;
    logic [LEN_W-1:0]   chunk_len;
    logic               msg_end;
    logic               q_valid;
    logic               q_pop;
    logic [ENTRY_W-1:0] q_entry;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.crc_poly      <= RST_CRC_POLY;
            cfg_reg.crc_width     <= RST_CRC_WIDTH;
            cfg_reg.nibble_mode   <= RST_NIBBLE_MODE;
            cfg_reg.message_bytes <= RST_MESSAGE_BYTES;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CRC_POLY:      cfg_reg.crc_poly      <= cfg_data[POLY_W-1:0];
                CFG_CRC_WIDTH:     cfg_reg.crc_width     <= cfg_data[CRC_WW-1:0];
                CFG_NIBBLE_MODE:   cfg_reg.nibble_mode   <= cfg_data[0];
                CFG_MESSAGE_BYTES: cfg_reg.message_bytes <= cfg_data[MSG_W-1:0];
                default:           ;
            endcase
        end
    end

    // front: codeword computation
    ccp_front #(
        .CRC_W   (CRC_W),
        .CHUNK_W (CHUNK_W),
        .LEN_W   (LEN_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .msg_in    (msg_in),
        .full      (full),
        .push      (push),
        .chunk     (chunk),
        .chunk_len (chunk_len),
        .msg_end   (msg_end)
    );

    // chunk queue
    ccp_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({msg_end, chunk_len, chunk}),
        .full      (full),
        .pop       (q_pop),
        .pop_data  (q_entry),
        .not_empty (q_valid)
    );

    // back: bit packing and output
    ccp_back #(
        .CHUNK_W (CHUNK_W),
        .LEN_W   (LEN_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_chunk  (q_entry[CHUNK_W-1:0]),
        .q_len    (q_entry[CHUNK_W +: LEN_W]),
        .q_end    (q_entry[ENTRY_W-1]),
        .q_pop    (q_pop),
        .code_out (code_out)
    );

endmodule

`default_nettype wire

// ===== rtl/ccp_checker.sv =====
// port-level checker for the crc codeword packer and its bind
`default_nettype none
`include "crc_codeword_packer_assert.svh"

module ccp_checker import ccp_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [BYTE_W-1:0] out_byte,
    input logic              last_out
);

    logic hdr_exp_reg;
    logic in_seen_reg;

    // track where a header item is due and whether any item came in
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_exp_reg <= 1'b1;
            in_seen_reg <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                hdr_exp_reg <= last_out;
            end
            if (in_valid && in_ready)
            begin
                in_seen_reg <= 1'b1;
            end
        end
    end

    // a stalled output item holds
    `CCP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_out), "stalled output item changed")

    // a header opens each message, holds a pad count below eight and is never last
    `CCP_ASSERT(a_header, out_valid && hdr_exp_reg |-> out_byte[7:3] == 5'd0 && !last_out, "bad header item")

    // no output before any input
    `CCP_ASSERT(a_no_spurious, out_valid |-> in_seen_reg, "output item without input")

endmodule

bind crc_codeword_packer ccp_checker u_ccp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (msg_in.valid),
    .in_ready  (msg_in.ready),
    .out_valid (code_out.valid),
    .out_ready (code_out.ready),
    .out_byte  (code_out.out_byte),
    .last_out  (code_out.last_out)
);

`default_nettype wire

// ===== test/tb_crc_codeword_packer.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the crc codeword packer with its own packing predictor

module tb_crc_codeword_packer;
    import ccp_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 8;
    localparam int MAX_CRC_WIDTH = DEFAULT_MAX_CRC_WIDTH;
    localparam int WIDTH_CAP     = (MAX_CRC_WIDTH > POLY_W) ? POLY_W : MAX_CRC_WIDTH;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 46;

    // one packed output byte as the receiver sees it
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } code_byte_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ccp_in_if  msg_ch ();
    ccp_out_if code_ch ();

    crc_codeword_packer u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_in    (msg_ch),
        .code_out  (code_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow registers and packing state of the predictor
    logic [POLY_W-1:0] poly_reg;
    logic [CRC_WW-1:0] width_reg;
    logic              nibble_reg;
    logic [MSG_W-1:0]  msg_len_reg;
    logic [63:0]       pack_bits;
    int                pack_fill;
    logic [MSG_W-1:0]  msg_pos;

    code_byte_t expected_bytes[$];

    int src_idle_pct;
    int rcv_stall_pct;
    int hold_seq;
    int hold_seen;
    int hold_left;
    int quiet_cycles;
    int fault_count;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic void reset_shadow();
        poly_reg    = RST_CRC_POLY;
        width_reg   = RST_CRC_WIDTH;
        nibble_reg  = RST_NIBBLE_MODE;
        msg_len_reg = RST_MESSAGE_BYTES;
        pack_bits   = '0;
        pack_fill   = 0;
        msg_pos     = '0;
    endfunction

    // register write as the block applies it, unused indexes dropped
    function automatic void shadow_write(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_CRC_POLY:      poly_reg = val[POLY_W-1:0];
            CFG_CRC_WIDTH:     width_reg = val[CRC_WW-1:0];
            CFG_NIBBLE_MODE:   nibble_reg = val[0];
            CFG_MESSAGE_BYTES: msg_len_reg = val[MSG_W-1:0];
            default: ;
        endcase
    endfunction

    // bitwise mod-2 division of the dataword followed by w zeros
    function automatic logic [POLY_W-1:0] mod2_rem(input logic [BYTE_W-1:0] dw,
                                                   input int nbits, input int w);
        logic [POLY_W-1:0] mask;
        logic [POLY_W-1:0] poly;
        logic [POLY_W-1:0] r;
        logic              fb;
        int                i;
        if (w == 0)
            return '0;
        mask = POLY_W'((32'd1 << w) - 32'd1);
        poly = poly_reg & mask;
        r    = '0;
        for (i = nbits - 1; i >= 0; i--)
        begin
            fb = dw[i] ^ r[w-1];
            r  = (r << 1) & mask;
            if (fb)
                r = r ^ poly;
        end
        return r;
    endfunction

    // expected output bytes caused by one message byte
    function automatic void pack_codewords(input logic [BYTE_W-1:0] b);
        int                w;
        int                msg;
        int                dw_bits;
        int                n_dw;
        int                pad;
        int                k;
        logic [BYTE_W-1:0] dw;
        logic [63:0]       code;
        code_byte_t        item_out[$];
        w       = (int'(width_reg) > WIDTH_CAP) ? WIDTH_CAP : int'(width_reg);
        msg     = (msg_len_reg == 0) ? 1 : int'(msg_len_reg);
        dw_bits = nibble_reg ? 4 : 8;
        n_dw    = nibble_reg ? 2 : 1;

        // header byte and leading zero pad on the first byte of a message
        if (msg_pos == 0)
        begin
            pad = (8 - ((msg * n_dw * (dw_bits + w)) % 8)) % 8;
            item_out.insert(item_out.size(), {BYTE_W'(pad), 1'b0});
            pack_bits = '0;
            pack_fill = pad;
        end

        // codewords in, whole bytes out
        for (k = 0; k < n_dw; k++)
        begin
            if (nibble_reg)
                dw = (k == 0) ? {4'h0, b[7:4]} : {4'h0, b[3:0]};
            else
                dw = b;
            code      = (64'(dw) << w) | 64'(mod2_rem(dw, dw_bits, w));
            pack_bits = (pack_bits << (dw_bits + w)) | code;
            pack_fill = pack_fill + dw_bits + w;
            while (pack_fill >= 8)
            begin
                pack_fill = pack_fill - 8;
                item_out.insert(item_out.size(), {pack_bits[pack_fill +: BYTE_W], 1'b0});
                pack_bits = pack_bits & ((64'd1 << pack_fill) - 64'd1);
            end
        end

        // message end: flush leftover bits and mark the final byte
        msg_pos = msg_pos + 1'b1;
        if (int'(msg_pos) >= msg)
        begin
            if (pack_fill > 0)
                item_out.insert(item_out.size(),
                                {BYTE_W'(pack_bits << (8 - pack_fill)), 1'b0});
            if (item_out.size() > 0)
                item_out[item_out.size() - 1].last = 1'b1;
            pack_bits = '0;
            pack_fill = 0;
            msg_pos   = '0;
        end

        foreach (item_out[j])
            expected_bytes.insert(expected_bytes.size(), item_out[j]);
    endfunction

    // ------------------------------------------------------------------
    // receiver, result check and watchdog
    // ------------------------------------------------------------------

    // random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            code_ch.ready <= 1'b0;
            hold_seen     <= hold_seq;
            hold_left     <= 0;
        end
        else if (hold_seq != hold_seen)
        begin
            hold_seen     <= hold_seq;
            hold_left     <= HOLD_CYCLES;
            code_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            code_ch.ready <= 1'b0;
        end
        else
        begin
            code_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // compare each accepted output item with the oldest expectation
    always @(posedge clk)
    begin : check_results
        code_byte_t want;
        if (rst_n && code_ch.valid && code_ch.ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected item out_byte %02h last_out %0b", $time,
                         code_ch.out_byte, code_ch.last_out);
                fault_count++;
            end
            else
            begin
                want = expected_bytes[0];
                expected_bytes.delete(0);
                if (code_ch.out_byte !== want.data)
                begin
                    $display("%0t: out_byte expected %02h, got %02h", $time, want.data,
                             code_ch.out_byte);
                    fault_count++;
                end
                if (code_ch.last_out !== want.last)
                begin
                    $display("%0t: last_out expected %0b, got %0b", $time, want.last,
                             code_ch.last_out);
                    fault_count++;
                end
            end
        end
    end

    // ends the run when neither channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (msg_ch.valid && msg_ch.ready) || (code_ch.valid && code_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // driver tasks
    // ------------------------------------------------------------------

    // offer one message byte, with a random gap in front, until taken
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if ($urandom_range(99) < src_idle_pct)
        begin
            msg_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        msg_ch.valid     <= 1'b1;
        msg_ch.data_byte <= b;
        do
            @(posedge clk);
        while (!msg_ch.ready);
        pack_codewords(b);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_write(idx, val);
        @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] poly, input logic [CFG_DATA_W-1:0] w,
                             input logic [CFG_DATA_W-1:0] nib, input logic [CFG_DATA_W-1:0] len);
        write_reg(CFG_CRC_POLY, poly);
        write_reg(CFG_CRC_WIDTH, w);
        write_reg(CFG_NIBBLE_MODE, nib);
        write_reg(CFG_MESSAGE_BYTES, len);
    endtask

    // stop offering, wait for every expected item, then let the pipe settle
    task automatic wait_idle();
        msg_ch.valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_idling(input int src, input int rcv);
        src_idle_pct = src;
        rcv_stall_pct <= rcv;
    endtask

    // random register set, width mostly in range with the edges weighted in
    task automatic random_config();
        logic [CFG_DATA_W-1:0] wd;
        logic [CFG_DATA_W-1:0] len;
        case ($urandom_range(9))
            0:       wd = '0;
            1:       wd = CFG_DATA_W'(POLY_W);
            2:       wd = CFG_DATA_W'($urandom_range(17, 31));
            default: wd = CFG_DATA_W'($urandom_range(1, 15));
        endcase
        // junk above the width field is masked off by the block
        wd[CFG_DATA_W-1:CRC_WW] = (CFG_DATA_W - CRC_WW)'($urandom);
        len = ($urandom_range(19) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 6));
        configure(CFG_DATA_W'($urandom), wd, CFG_DATA_W'($urandom), len);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset values: every byte is a one-byte message with a 3-bit crc
    task automatic test_defaults();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h96);
    endtask

    // zero width leaves the dataword alone; totals here are byte aligned
    task automatic test_zero_width();
        wait_idle();
        configure(16'h1234, 16'd0, 16'd1, 16'd2);
        send_byte(8'hA5);
        send_byte(8'h5A);
        wait_idle();
        configure(16'h0007, 16'd8, 16'd0, 16'd1);
        send_byte(8'h01);
    endtask

    // widths above the limit saturate, including the masked all-ones write
    task automatic test_width_limit();
        wait_idle();
        configure(16'hFFFF, 16'hFFFF, 16'd1, 16'd1);
        send_byte(8'hFF);
        wait_idle();
        configure(16'h8005, 16'd17, 16'd0, 16'd2);
        send_byte(8'h80);
        send_byte(8'h7F);
    endtask

    // zero message length behaves as one byte per message
    task automatic test_zero_length();
        wait_idle();
        configure(16'h0003, 16'd3, 16'd0, 16'd0);
        send_byte(8'h55);
        send_byte(8'hAA);
    endtask

    // writes to indexes past the register list change nothing
    task automatic test_unused_index();
        int idx;
        wait_idle();
        for (idx = int'(CFG_MESSAGE_BYTES) + 1; idx < (1 << CFG_IDX_W); idx++)
            write_reg(CFG_IDX_W'(idx), CFG_DATA_W'($urandom));
        send_byte(8'hC3);
    endtask

    // registers changed inside a message, then a lowered length ends it
    task automatic test_mid_message_change();
        wait_idle();
        configure(16'h0009, 16'd5, 16'd0, 16'hFFFF);
        send_byte(8'h12);
        send_byte(8'hE7);
        send_byte(8'h3C);
        wait_idle();
        write_reg(CFG_CRC_WIDTH, 16'd7);
        send_byte(8'h81);
        wait_idle();
        write_reg(CFG_MESSAGE_BYTES, 16'd2);
        send_byte(8'h4B);
        wait_idle();
        configure(16'h0000, 16'd8, 16'd1, 16'd3);
        send_byte(8'h0F);
        send_byte(8'hF0);
        send_byte(8'h69);
    endtask

    // receiver holds off long enough for the input queue to fill
    task automatic test_backpressure();
        int n;
        wait_idle();
        set_idling(0, 0);
        configure(16'hC002, 16'd16, 16'd1, 16'd4);
        hold_seq <= hold_seq + 1;
        for (n = 0; n < 12; n++)
            send_byte(BYTE_W'($urandom));
        wait_idle();
    endtask

    // mostly whole messages under random settings, some cut short
    task automatic test_random_phase(input int src, input int rcv, input int n_items);
        int sent;
        int len;
        int count;
        int n;
        bit partial;
        sent    = 0;
        partial = 1'b1;
        set_idling(src, rcv);
        while (sent < n_items)
        begin
            if (partial || $urandom_range(1) == 1)
            begin
                wait_idle();
                random_config();
            end
            len = (msg_len_reg == 0) ? 1 : int'(msg_len_reg);
            count = (int'(msg_pos) < len) ? len - int'(msg_pos) : 1;
            partial = ($urandom_range(99) < 15) && (count > 1);
            if (partial)
                count = $urandom_range(1, count - 1);
            for (n = 0; n < count; n++)
                send_byte(BYTE_W'($urandom));
            sent = sent + count;
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        msg_ch.valid      = 1'b0;
        msg_ch.data_byte  = '0;
        code_ch.ready     = 1'b0;
        src_idle_pct      = 0;
        rcv_stall_pct     = 0;
        hold_seq          = 0;
        fault_count       = 0;
        quiet_cycles      = 0;
        reset_shadow();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_zero_width();
        test_width_limit();
        test_zero_length();
        test_unused_index();
        test_mid_message_change();
        test_backpressure();
        test_random_phase(0, 0, PHASE_ITEMS);
        test_random_phase(66, 0, PHASE_ITEMS);
        test_random_phase(0, 66, PHASE_ITEMS);
        test_random_phase(7, 7, PHASE_ITEMS);

        // drain and watch for stray items
        wait_idle();
        repeat (END_CYCLES) @(posedge clk);
        if (fault_count == 0 && expected_bytes.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== crc_codeword_packer.f =====
+incdir+rtl
rtl/ccp_pkg.sv
rtl/ccp_if.sv
rtl/ccp_fifo.sv
rtl/ccp_front.sv
rtl/ccp_back.sv
rtl/crc_codeword_packer.sv
rtl/ccp_checker.sv
test/tb_crc_codeword_packer.sv
